// ===== hw/rtl/fsc_pkg.sv =====
// Shared types and constants of the floppy soft-switch controller.
// Used by every module under hw/rtl; depends on nothing.
package fsc_pkg;

  localparam int ELAPSED_W = 24;
  localparam logic [ELAPSED_W-1:0] DELAY_RESET   = 24'd1020484;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = 24'hFFFFFF;

  // Request kinds carried in the opcode field
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } opcode_t;

  // Spindle commands sent to the disk side
  typedef enum logic [1:0] {
    SPIN_NONE  = 2'd0,
    SPIN_START = 2'd1,
    SPIN_STOP  = 2'd2
  } spin_cmd_t;

  // Soft switch numbers
  localparam logic [3:0] SW_PHASE_LAST = 4'd7;
  localparam logic [3:0] SW_MOTOR_OFF  = 4'd8;
  localparam logic [3:0] SW_MOTOR_ON   = 4'd9;
  localparam logic [3:0] SW_DRIVE0     = 4'd10;
  localparam logic [3:0] SW_DRIVE1     = 4'd11;
  localparam logic [3:0] SW_Q6_CLR     = 4'd12;
  localparam logic [3:0] SW_Q6_SET     = 4'd13;
  localparam logic [3:0] SW_Q7_CLR     = 4'd14;
  localparam logic [3:0] SW_Q7_SET     = 4'd15;

  // Request fields, highest bits first (opcode sits in the lowest bits)
  typedef struct packed {
    logic       write_protect;
    logic [3:0] disk_bit_count;
    logic [7:0] disk_bits;
    logic [7:0] tick_cycles;
    logic [3:0] switch_address;
    logic [1:0] opcode;
  } item_t;

  // Decoded request, one flag per action
  typedef struct packed {
    logic is_tick;
    logic is_read;
    logic phase;
    logic motor_off;
    logic motor_on;
    logic drive_sel;
    logic q6_clr;
    logic q6_set;
    logic q7_clr;
    logic q7_set;
  } decode_t;

  typedef struct packed {
    spin_cmd_t spin_cmd;
    logic      spin_drive;
    logic      active_drive;
    logic      running_next;
  } motor_res_t;

  // Result fields, highest bits first (read_data sits in the lowest bits)
  typedef struct packed {
    logic       active_drive;
    logic       spin_drive;
    spin_cmd_t  spin_cmd;
    logic       phase_on;
    logic [1:0] phase_index;
    logic       phase_cmd_valid;
    logic [7:0] read_data;
  } result_t;

endpackage

// ===== hw/rtl/fsc_decode.sv =====
// Request decoder: opcode and soft switch number to action flags.
// Depends on fsc_pkg.
module fsc_decode
  import fsc_pkg::*;
(
  input  logic [1:0] opcode,
  input  logic [3:0] switch_address,
  output decode_t    dec
);

  logic access;

  // Classify the request kind
  always_comb begin
    dec    = '0;
    access = 1'b0;
    case (opcode)
      OP_TICK: begin
        dec.is_tick = 1'b1;
      end
      OP_READ: begin
        dec.is_read = 1'b1;
        access      = 1'b1;
      end
      OP_WRITE: begin
        access = 1'b1;
      end
      default: begin
        access = 1'b0;
      end
    endcase

    // Decode the switch on bus accesses
    if (access) begin
      dec.phase     = switch_address inside {[4'd0:SW_PHASE_LAST]};
      dec.motor_off = (switch_address == SW_MOTOR_OFF);
      dec.motor_on  = (switch_address == SW_MOTOR_ON);
      dec.drive_sel = switch_address inside {SW_DRIVE0, SW_DRIVE1};
      dec.q6_clr    = (switch_address == SW_Q6_CLR);
      dec.q6_set    = (switch_address == SW_Q6_SET);
      dec.q7_clr    = (switch_address == SW_Q7_CLR);
      dec.q7_set    = (switch_address == SW_Q7_SET);
    end
  end

endmodule

// ===== hw/rtl/fsc_motor.sv =====
// Motor start/stop timers and drive selection.
// Depends on fsc_pkg; fed by fsc_decode.
module fsc_motor
  import fsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  decode_t              dec,
  input  logic                 sel_drive,
  input  logic [7:0]           tick_cycles,
  input  logic [ELAPSED_W-1:0] motor_delay_cycles,
  output motor_res_t           res
);

  logic                 motor_running, motor_running_next;
  logic                 start_pending, start_pending_next;
  logic                 stop_pending, stop_pending_next;
  logic [ELAPSED_W-1:0] start_elapsed, start_elapsed_next;
  logic [ELAPSED_W-1:0] stop_elapsed, stop_elapsed_next;
  logic                 current_drive, current_drive_next;
  logic                 pending_drive, pending_drive_next;
  logic [ELAPSED_W:0]   sum;
  logic [ELAPSED_W-1:0] sum_sat;

  // Shared saturating add: start timer wins when both are pending
  always_comb begin
    sum     = {1'b0, (start_pending ? start_elapsed : stop_elapsed)}
              + {{(ELAPSED_W-7){1'b0}}, tick_cycles};
    sum_sat = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
  end

  // Next state and command outputs
  always_comb begin
    motor_running_next = motor_running;
    start_pending_next = start_pending;
    stop_pending_next  = stop_pending;
    start_elapsed_next = start_elapsed;
    stop_elapsed_next  = stop_elapsed;
    current_drive_next = current_drive;
    pending_drive_next = pending_drive;
    res.spin_cmd       = SPIN_NONE;
    res.spin_drive     = 1'b0;

    if (dec.is_tick) begin
      if (start_pending) begin
        start_elapsed_next = sum_sat;
        if (sum_sat >= motor_delay_cycles) begin
          start_pending_next = 1'b0;
          motor_running_next = 1'b1;
        end
        current_drive_next = pending_drive;
      end else if (stop_pending) begin
        stop_elapsed_next = sum_sat;
        if (sum_sat >= motor_delay_cycles) begin
          stop_pending_next  = 1'b0;
          motor_running_next = 1'b0;
          res.spin_cmd       = SPIN_STOP;
          res.spin_drive     = current_drive;
        end
        current_drive_next = pending_drive;
      end
    end

    if (dec.phase) begin
      res.spin_drive = current_drive;
    end

    if (dec.motor_off) begin
      start_pending_next = 1'b0;
      stop_pending_next  = 1'b1;
      stop_elapsed_next  = '0;
    end

    if (dec.motor_on) begin
      stop_pending_next  = 1'b0;
      start_pending_next = 1'b1;
      start_elapsed_next = '0;
      res.spin_cmd       = SPIN_START;
      res.spin_drive     = current_drive;
    end

    // Drive change while spinning forces a stop of the old drive
    if (dec.drive_sel) begin
      pending_drive_next = sel_drive;
      if (motor_running && (current_drive != sel_drive)) begin
        stop_pending_next = 1'b1;
        stop_elapsed_next = '0;
      end
    end

    res.active_drive = current_drive_next;
    res.running_next = motor_running_next;
  end

  // Hold state between accepted requests
  always_ff @(posedge clk) begin
    if (rst) begin
      motor_running <= 1'b0;
      start_pending <= 1'b0;
      stop_pending  <= 1'b0;
      start_elapsed <= '0;
      stop_elapsed  <= '0;
      current_drive <= 1'b0;
      pending_drive <= 1'b0;
    end else if (fire) begin
      motor_running <= motor_running_next;
      start_pending <= start_pending_next;
      stop_pending  <= stop_pending_next;
      start_elapsed <= start_elapsed_next;
      stop_elapsed  <= stop_elapsed_next;
      current_drive <= current_drive_next;
      pending_drive <= pending_drive_next;
    end
  end

  a_motor_on_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && dec.motor_on |=> start_pending && !stop_pending && start_elapsed == '0)
    else $error("motor-on switch did not restart the start timer");

  a_tick_copies_drive: assert property (@(posedge clk) disable iff (rst)
    fire && dec.is_tick && (start_pending || stop_pending)
      |=> current_drive == $past(pending_drive))
    else $error("tick with pending motor change did not copy the drive");

  a_run_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(motor_running) |-> $past(fire && dec.is_tick && start_pending))
    else $error("motor started without a pending start on a tick");

endmodule

// ===== hw/rtl/fsc_data.sv =====
// Read latch, Q6/Q7 latches, status register and read data.
// Depends on fsc_pkg; fed by fsc_decode and fsc_motor.
module fsc_data
  import fsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  decode_t    dec,
  input  logic       running_next,
  input  logic [7:0] disk_bits,
  input  logic [3:0] disk_bit_count,
  input  logic       write_protect,
  output logic [7:0] read_data
);

  logic [7:0] read_latch, read_latch_next;
  logic       q6, q6_next;
  logic       q7, q7_next;
  logic       status_wp, status_wp_next;
  logic [7:0] latch_base;
  logic [7:0] latch_shift;

  // Shift disk bits into the latch; clear it first once a byte is complete
  always_comb begin
    latch_base      = read_latch[7] ? 8'd0 : read_latch;
    latch_shift     = latch_base << disk_bit_count;
    read_latch_next = read_latch;
    if (dec.is_tick && running_next && (disk_bit_count != 4'd0)) begin
      read_latch_next = latch_shift | disk_bits;
    end
  end

  // Update Q6/Q7 and sample write protect while in sense mode
  always_comb begin
    q6_next = q6;
    q7_next = q7;
    if (dec.q6_clr) q6_next = 1'b0;
    if (dec.q6_set) q6_next = 1'b1;
    if (dec.q7_clr) q7_next = 1'b0;
    if (dec.q7_set) q7_next = 1'b1;
    status_wp_next = status_wp;
    if ((dec.q6_clr || dec.q6_set || dec.q7_clr || dec.q7_set) && q6_next) begin
      status_wp_next = write_protect;
    end
  end

  // Select read data
  always_comb begin
    read_data = 8'd0;
    if (dec.is_read && dec.q6_clr && !q7) begin
      read_data = read_latch;
    end else if (dec.is_read && dec.q7_clr && q6) begin
      read_data = {status_wp_next, 7'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_latch <= 8'd0;
      q6         <= 1'b0;
      q7         <= 1'b0;
      status_wp  <= 1'b0;
    end else if (fire) begin
      read_latch <= read_latch_next;
      q6         <= q6_next;
      q7         <= q7_next;
      status_wp  <= status_wp_next;
    end
  end

  a_q6_set_samples_wp: assert property (@(posedge clk) disable iff (rst)
    fire && dec.q6_set |=> q6 && status_wp == $past(write_protect))
    else $error("Q6 set did not sample write protect");

  a_latch_frozen_stopped: assert property (@(posedge clk) disable iff (rst)
    fire && !running_next |=> $stable(read_latch))
    else $error("read latch moved while the motor was stopped");

endmodule

// ===== hw/rtl/floppy_soft_switch_controller.sv =====
// Top level of the floppy soft-switch controller: request register, decode,
// motor and data units, result register. Depends on fsc_pkg, fsc_decode,
// fsc_motor and fsc_data.
//
//  Channel   Dir  Handshake           Payload
//  s_*       in   s_tvalid/s_tready   s_tdata[26:0]: request fields
//  m_*       out  m_tvalid/m_tready   m_tdata[15:0]: result fields
//  cfg_*     in   cfg_we              cfg_wdata[23:0]: motor delay in cycles
//
// One request per clock while the output is not stalled; each passes through the
// request register, then decode and state update into the result register.
// A stalled output holds the result register, then the request register;
// s_tready stays high while either has room.
// rst clears both registers' valid flags, all controller state, and loads
// the motor delay with its default.
module floppy_soft_switch_controller
  import fsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] opcode, [5:2] switch_address, [13:6] tick_cycles, [21:14] disk_bits,
  // [25:22] disk_bit_count, [26] write_protect, [31:27] zero
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] read_data, [8] phase_cmd_valid, [10:9] phase_index, [11] phase_on,
  // [13:12] spin_cmd, [14] spin_drive, [15] active_drive
  output logic [15:0] m_tdata,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata
);

  item_t                item;
  logic                 in_valid;
  logic                 out_valid;
  result_t              result, result_next;
  logic                 out_free;
  logic                 fire;
  logic [ELAPSED_W-1:0] motor_delay_cycles;
  decode_t              dec;
  motor_res_t           mres;
  logic [7:0]           read_data;

  // Advance when the result register has room
  assign out_free = !out_valid || m_tready;
  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      motor_delay_cycles <= DELAY_RESET;
    end else if (cfg_we) begin
      motor_delay_cycles <= cfg_wdata;
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= s_tdata[$bits(item_t)-1:0];
    end
  end

  fsc_decode u_decode (
    .opcode         (item.opcode),
    .switch_address (item.switch_address),
    .dec            (dec)
  );

  fsc_motor u_motor (
    .clk                (clk),
    .rst                (rst),
    .fire               (fire),
    .dec                (dec),
    .sel_drive          (item.switch_address[0]),
    .tick_cycles        (item.tick_cycles),
    .motor_delay_cycles (motor_delay_cycles),
    .res                (mres)
  );

  fsc_data u_data (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .dec            (dec),
    .running_next   (mres.running_next),
    .disk_bits      (item.disk_bits),
    .disk_bit_count (item.disk_bit_count),
    .write_protect  (item.write_protect),
    .read_data      (read_data)
  );

  // Assemble the result
  always_comb begin
    result_next.read_data       = read_data;
    result_next.phase_cmd_valid = dec.phase;
    result_next.phase_index     = dec.phase ? item.switch_address[2:1] : 2'd0;
    result_next.phase_on        = dec.phase & item.switch_address[0];
    result_next.spin_cmd        = mres.spin_cmd;
    result_next.spin_drive      = mres.spin_drive;
    result_next.active_drive    = mres.active_drive;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = result;

  a_ready_when_room: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("request side stalled with an empty result register");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed request produced no result");

endmodule

// ===== sim/floppy_soft_switch_controller_tb.sv =====
// Self-checking testbench for the floppy soft-switch controller.
// Drives request streams with random gaps, predicts every response in-line and
// compares field by field; depends on fsc_pkg and floppy_soft_switch_controller.
module floppy_soft_switch_controller_tb;
  import fsc_pkg::*;

  localparam logic [1:0] OP_IGNORED  = 2'd3;
  localparam int         CYCLE_LIMIT = 2000000;
  localparam int         PHASE_ITEMS = 85;

  typedef struct {
    item_t req;
    bit    drain_first;
  } queued_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;

  // Predicted controller state
  logic [23:0] delay_setting = DELAY_RESET;
  logic        spindle_running = 1'b0;
  logic        start_wait = 1'b0;
  logic        stop_wait = 1'b0;
  logic [23:0] start_count = '0;
  logic [23:0] stop_count = '0;
  logic        drive_now = 1'b0;
  logic        drive_next = 1'b0;
  logic [7:0]  shift_latch = '0;
  logic        q6 = 1'b0;
  logic        q7 = 1'b0;
  logic [7:0]  status_reg = '0;

  queued_req_t request_queue[$];
  result_t     expected_responses[$];
  item_t       active_req;
  queued_req_t head_req;
  result_t     want;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          queued_items = 0;
  bit          idle_enable = 1'b1;
  bit          drain_pending = 1'b0;

  floppy_soft_switch_controller i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Compute the response to one request and advance the predicted state
  function automatic result_t controller_response(item_t req);
    result_t     res;
    logic [24:0] sum;
    logic [15:0] shifted;
    logic [7:0]  base;
    res = '0;
    case (req.opcode)
      OP_TICK: begin
        if (start_wait) begin
          sum = {1'b0, start_count} + req.tick_cycles;
          start_count = sum[24] ? ELAPSED_MAX : sum[23:0];
          if (start_count >= delay_setting) begin
            start_wait = 1'b0;
            spindle_running = 1'b1;
          end
          drive_now = drive_next;
        end else if (stop_wait) begin
          sum = {1'b0, stop_count} + req.tick_cycles;
          stop_count = sum[24] ? ELAPSED_MAX : sum[23:0];
          if (stop_count >= delay_setting) begin
            stop_wait = 1'b0;
            spindle_running = 1'b0;
            res.spin_cmd = SPIN_STOP;
            res.spin_drive = drive_now;
          end
          drive_now = drive_next;
        end
        // Shift disk bits in; a full byte (bit 7 set) is dropped first
        if (spindle_running && req.disk_bit_count != 4'd0) begin
          base = shift_latch[7] ? 8'h00 : shift_latch;
          shifted = ({8'h00, base} << req.disk_bit_count) | {8'h00, req.disk_bits};
          shift_latch = shifted[7:0];
        end
      end
      OP_READ, OP_WRITE: begin
        if (req.switch_address <= SW_PHASE_LAST) begin
          res.phase_cmd_valid = 1'b1;
          res.phase_index = req.switch_address[2:1];
          res.phase_on = req.switch_address[0];
          res.spin_drive = drive_now;
        end else begin
          case (req.switch_address)
            SW_MOTOR_OFF: begin
              start_wait = 1'b0;
              stop_wait = 1'b1;
              stop_count = '0;
            end
            SW_MOTOR_ON: begin
              stop_wait = 1'b0;
              start_wait = 1'b1;
              start_count = '0;
              res.spin_cmd = SPIN_START;
              res.spin_drive = drive_now;
            end
            SW_DRIVE0, SW_DRIVE1: begin
              drive_next = req.switch_address[0];
              if (spindle_running && drive_now != drive_next) begin
                stop_wait = 1'b1;
                stop_count = '0;
              end
            end
            SW_Q6_CLR: begin
              q6 = 1'b0;
              if (req.opcode == OP_READ && !q7) res.read_data = shift_latch;
            end
            SW_Q6_SET: begin
              q6 = 1'b1;
              status_reg[7] = req.write_protect;
            end
            SW_Q7_CLR: begin
              if (q6) status_reg[7] = req.write_protect;
              q7 = 1'b0;
              if (req.opcode == OP_READ && q6) res.read_data = status_reg;
            end
            default: begin
              if (q6) status_reg[7] = req.write_protect;
              q7 = 1'b1;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    res.active_drive = drive_now;
    return res;
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enable || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Mostly full bytes, sometimes partial, rarely more than a byte
  function automatic logic [3:0] random_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 4'd8;
    if (r < 9) return 4'($urandom_range(0, 8));
    return 4'($urandom_range(9, 15));
  endfunction

  task automatic add_request(input logic [1:0] op, input logic [3:0] sw,
                             input logic [7:0] cyc, input logic [7:0] bits,
                             input logic [3:0] cnt, input logic wp);
    queued_req_t q;
    q.req.opcode = op;
    q.req.switch_address = sw;
    q.req.tick_cycles = cyc;
    q.req.disk_bits = bits;
    q.req.disk_bit_count = cnt;
    q.req.write_protect = wp;
    q.drain_first = drain_pending;
    drain_pending = 1'b0;
    request_queue.push_back(q);
    if (op != OP_IGNORED) queued_items++;
  endtask

  task automatic add_access(input logic [3:0] sw);
    add_request($urandom_range(0, 1) ? OP_READ : OP_WRITE, sw, 8'($urandom),
                8'($urandom), 4'($urandom), 1'($urandom));
  endtask

  task automatic add_tick(input logic [3:0] cnt);
    add_request(OP_TICK, 4'($urandom), 8'($urandom), 8'($urandom), cnt, 1'($urandom));
  endtask

  // Build one random phase out of short well-formed sequences and some noise
  task automatic queue_random_phase(input int budget);
    int first, kind, n;
    first = queued_items;
    drain_pending = 1'b1;
    while (queued_items - first < budget) begin
      if ($urandom_range(0, 39) == 0) drain_pending = 1'b1;
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: begin
          add_access(SW_MOTOR_ON);
          n = $urandom_range(2, 8);
          repeat (n) add_tick(random_count());
        end
        2, 3: begin
          n = $urandom_range(3, 10);
          repeat (n) begin
            add_tick(random_count());
            add_request($urandom_range(0, 3) != 0 ? OP_READ : OP_WRITE, SW_Q6_CLR,
                        8'($urandom), 8'($urandom), 4'($urandom), 1'($urandom));
          end
        end
        4: begin
          add_access(SW_Q6_SET);
          add_access(SW_Q7_CLR);
          add_access(SW_Q7_SET);
          add_access(SW_Q7_CLR);
          add_access(SW_Q6_CLR);
        end
        5: begin
          add_access($urandom_range(0, 1) ? SW_DRIVE1 : SW_DRIVE0);
          n = $urandom_range(1, 6);
          repeat (n) add_tick(random_count());
        end
        6: begin
          add_access(SW_MOTOR_OFF);
          n = $urandom_range(1, 6);
          repeat (n) add_tick(random_count());
        end
        7: begin
          n = $urandom_range(1, 4);
          repeat (n) add_access(4'($urandom_range(0, 7)));
        end
        default: begin
          n = $urandom_range(1, 4);
          repeat (n)
            add_request(2'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
                        4'($urandom), 1'($urandom));
        end
      endcase
    end
  endtask

  // Let the pipeline empty
  task automatic wait_drained();
    do @(negedge clk);
    while (request_queue.size() != 0 || s_tvalid || expected_responses.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_delay(input logic [23:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    delay_setting = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic compare_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Request driver: present the next queued request, honor gaps and drains
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) expected_responses.push_back(controller_response(active_req));
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0 || request_queue.size() == 0 ||
            (request_queue[0].drain_first && expected_responses.size() != 0)) begin
          if (send_gap > 0) send_gap--;
          s_tvalid <= 1'b0;
        end else begin
          head_req = request_queue.pop_front();
          active_req = head_req.req;
          s_tdata <= {5'b0, active_req.write_protect, active_req.disk_bit_count,
                      active_req.disk_bits, active_req.tick_cycles,
                      active_req.switch_address, active_req.opcode};
          s_tvalid <= 1'b1;
          send_gap = pick_gap();
        end
      end
    end
  end

  // Response monitor: check each response against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_responses.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %0h", $time, m_tdata);
          mismatch_count++;
        end else begin
          want = expected_responses.pop_front();
          compare_field("read_data", want.read_data, m_tdata[7:0]);
          compare_field("phase_cmd_valid", 8'(want.phase_cmd_valid), 8'(m_tdata[8]));
          compare_field("phase_index", 8'(want.phase_index), 8'(m_tdata[10:9]));
          compare_field("phase_on", 8'(want.phase_on), 8'(m_tdata[11]));
          compare_field("spin_cmd", 8'(want.spin_cmd), 8'(m_tdata[13:12]));
          compare_field("spin_drive", 8'(want.spin_drive), 8'(m_tdata[14]));
          compare_field("active_drive", 8'(want.active_drive), 8'(m_tdata[15]));
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default delay: ignored opcode, phases, Q6/Q7 and status reads
    add_request(OP_IGNORED, 4'hF, 8'hFF, 8'hFF, 4'hF, 1'b1);
    add_request(OP_READ, 4'd0, 8'h00, 8'h00, 4'h0, 1'b0);
    add_request(OP_WRITE, SW_PHASE_LAST, 8'hFF, 8'hFF, 4'hF, 1'b1);
    add_request(OP_READ, 4'd3, 8'h5A, 8'hA5, 4'h8, 1'b0);
    add_request(OP_WRITE, SW_Q6_SET, 8'h00, 8'h00, 4'h0, 1'b1);
    add_request(OP_READ, SW_Q7_CLR, 8'h00, 8'h00, 4'h0, 1'b1);
    add_request(OP_READ, SW_Q6_CLR, 8'h00, 8'h00, 4'h0, 1'b0);
    add_request(OP_WRITE, SW_Q7_SET, 8'h00, 8'h00, 4'h0, 1'b0);
    add_request(OP_READ, SW_Q6_CLR, 8'h00, 8'h00, 4'h0, 1'b1);
    add_request(OP_WRITE, SW_Q7_CLR, 8'h00, 8'h00, 4'h0, 1'b0);
    add_request(OP_TICK, 4'd0, 8'hFF, 8'hFF, 4'h8, 1'b0);
    wait_drained();

    // Zero delay: start on next tick, latch shifting, both pending, drive copy
    write_delay(24'd0);
    add_request(OP_READ, SW_MOTOR_ON, 8'h00, 8'h00, 4'h0, 1'b0);
    add_request(OP_TICK, 4'd0, 8'h00, 8'h05, 4'd3, 1'b0);
    add_request(OP_TICK, 4'd0, 8'h01, 8'hFF, 4'd8, 1'b0);
    add_request(OP_TICK, 4'd0, 8'h02, 8'h00, 4'd1, 1'b0);
    add_request(OP_TICK, 4'd0, 8'h03, 8'hA5, 4'd15, 1'b0);
    add_request(OP_TICK, 4'd0, 8'h04, 8'h3C, 4'd0, 1'b0);
    add_request(OP_READ, SW_Q6_CLR, 8'h00, 8'h00, 4'h0, 1'b0);
    add_request(OP_WRITE, SW_MOTOR_ON, 8'h00, 8'h00, 4'h0, 1'b0);
    add_request(OP_READ, SW_DRIVE1, 8'h00, 8'h00, 4'h0, 1'b0);
    add_request(OP_TICK, 4'd0, 8'h00, 8'h01, 4'd2, 1'b0);
    add_request(OP_TICK, 4'd0, 8'h00, 8'h01, 4'd2, 1'b0);
    add_request(OP_WRITE, SW_DRIVE0, 8'h00, 8'h00, 4'h0, 1'b0);
    add_request(OP_TICK, 4'd0, 8'hFF, 8'h00, 4'd0, 1'b0);
    add_request(OP_WRITE, SW_MOTOR_ON, 8'h00, 8'h00, 4'h0, 1'b0);
    add_request(OP_TICK, 4'd0, 8'h00, 8'h00, 4'd0, 1'b0);
    add_request(OP_WRITE, SW_MOTOR_OFF, 8'h00, 8'h00, 4'h0, 1'b0);
    add_request(OP_TICK, 4'd0, 8'h00, 8'h00, 4'd0, 1'b0);
    wait_drained();

    // Random phases across several delay settings, one without idling
    write_delay(24'd1);
    queue_random_phase(PHASE_ITEMS);
    wait_drained();
    write_delay(24'd0);
    idle_enable = 1'b0;
    queue_random_phase(PHASE_ITEMS);
    wait_drained();
    idle_enable = 1'b1;
    write_delay(24'($urandom_range(2, 700)));
    queue_random_phase(PHASE_ITEMS);
    wait_drained();
    write_delay(24'd300);
    queue_random_phase(PHASE_ITEMS);
    wait_drained();

    // Maximum delay: pending start and stop keep counting without completing
    write_delay(ELAPSED_MAX);
    idle_enable = 1'b0;
    add_access(SW_MOTOR_ON);
    repeat (8) add_request(OP_TICK, 4'($urandom), 8'd255, 8'($urandom),
                           random_count(), 1'($urandom));
    add_access(SW_MOTOR_OFF);
    repeat (8) add_request(OP_TICK, 4'($urandom), 8'd255, 8'($urandom),
                           random_count(), 1'($urandom));
    wait_drained();
    repeat (8) @(negedge clk);

    if (mismatch_count == 0 && expected_responses.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (expected_responses.size() != 0)
        $display("%0t: %0d responses never arrived", $time, expected_responses.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fsc_pkg.sv
hw/rtl/fsc_decode.sv
hw/rtl/fsc_motor.sv
hw/rtl/fsc_data.sv
hw/rtl/floppy_soft_switch_controller.sv
sim/floppy_soft_switch_controller_tb.sv
